@@ rtl/core/i2cm_pkg.sv @@
`default_nettype none

package i2cm_pkg;

    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 2;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT_TICKS = 2'd1;

    localparam logic [CFG_W-1:0] QUARTER_TICKS_RST  = 16'd125;
    localparam logic [CFG_W-1:0] ACK_WAIT_TICKS_RST = 16'd250;

    localparam logic [3:0] DATA_BITS    = 4'd8;
    localparam logic [3:0] RESET_CLOCKS = 4'd9;
    localparam int         MSB_INDEX    = 7;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_BRST  = 3'd5
    } t_cmd;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_START    = 11'b000_0000_0010,
        S_STOP     = 11'b000_0000_0100,
        S_WBIT     = 11'b000_0000_1000,
        S_RBIT     = 11'b000_0001_0000,
        S_WSTRETCH = 11'b000_0010_0000,
        S_RSTRETCH = 11'b000_0100_0000,
        S_WACK     = 11'b000_1000_0000,
        S_POLL     = 11'b001_0000_0000,
        S_RACK     = 11'b010_0000_0000,
        S_BRST     = 11'b100_0000_0000
    } t_state;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] write_data;
        logic       send_ack;
        logic       allow_stretch;
        logic       scl_in;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_seen;
    } t_out_item;

endpackage

`default_nettype wire

@@ rtl/core/i2cm_limit.sv @@
`default_nettype none

// Config value to counter limit: saturate to counter max, zero acts as one.
module i2cm_limit
    import i2cm_pkg::*;
#(
    parameter int COUNTER_WIDTH = 16
) (
    input  wire logic [CFG_W-1:0]         i_value,
    output logic      [COUNTER_WIDTH-1:0] o_limit
);

    logic [COUNTER_WIDTH-1:0] w_clamped;

    generate
        if (COUNTER_WIDTH >= CFG_W) begin : g_wide
            assign w_clamped = COUNTER_WIDTH'(i_value);
        end else begin : g_narrow
            assign w_clamped = (|i_value[CFG_W-1:COUNTER_WIDTH]) ? '1
                             : i_value[COUNTER_WIDTH-1:0];
        end
    endgenerate

    assign o_limit = (w_clamped == '0) ? COUNTER_WIDTH'(1) : w_clamped;

endmodule

`default_nettype wire

@@ rtl/core/i2cm_engine.sv @@
`default_nettype none

// Bit sequencer: one tick per step, result is the post-tick pin/status view.
module i2cm_engine
    import i2cm_pkg::*;
#(
    parameter int COUNTER_WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_step,
    input  wire t_in_item                 i_item,
    input  wire logic [COUNTER_WIDTH-1:0] i_qlim,
    input  wire logic [COUNTER_WIDTH-1:0] i_wlim,
    output t_out_item                     o_result
);

    localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);

    t_state                   r_state, n_state;
    logic [3:0]               r_bit_count, n_bit_count;
    logic [7:0]               r_shift, n_shift;
    logic [COUNTER_WIDTH-1:0] r_qcount, n_qcount;
    logic [1:0]               r_phase, n_phase;
    logic [COUNTER_WIDTH-1:0] r_awcount, n_awcount;
    logic                     r_scl, n_scl;
    logic                     r_sda, n_sda;
    logic                     r_ack_flag, n_ack_flag;
    logic                     r_ack_l, n_ack_l;
    logic                     r_str_l, n_str_l;
    logic [7:0]               r_rd_byte, n_rd_byte;

    logic   w_done;
    logic   w_ent;
    t_state w_ent_st;
    logic [1:0] w_ent_ph;
    logic   w_fin;
    logic   w_qtick;

    always_comb begin
        n_state     = r_state;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_qcount    = r_qcount;
        n_phase     = r_phase;
        n_awcount   = r_awcount;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_ack_flag  = r_ack_flag;
        n_ack_l     = r_ack_l;
        n_str_l     = r_str_l;
        n_rd_byte   = r_rd_byte;
        w_done      = 1'b0;
        w_ent       = 1'b0;
        w_ent_st    = S_IDLE;
        w_ent_ph    = 2'd0;
        w_fin       = 1'b0;
        w_qtick     = 1'b0;

        case (r_state)
            S_IDLE: begin
                case (i_item.cmd)
                    CMD_START: begin
                        w_ent = 1'b1; w_ent_st = S_START;
                    end
                    CMD_STOP: begin
                        w_ent = 1'b1; w_ent_st = S_STOP;
                    end
                    CMD_WRITE: begin
                        w_ent = 1'b1; w_ent_st = S_WBIT;
                        n_shift = i_item.write_data;
                    end
                    CMD_READ: begin
                        w_ent = 1'b1; w_ent_st = S_RBIT;
                        n_shift = '0;
                    end
                    CMD_BRST: begin
                        w_ent = 1'b1; w_ent_st = S_BRST;
                    end
                    default: ;
                endcase
                if (w_ent) begin
                    n_ack_l     = i_item.send_ack;
                    n_str_l     = i_item.allow_stretch;
                    n_bit_count = '0;
                end
            end
            S_WSTRETCH, S_RSTRETCH: begin
                if (i_item.scl_in) begin
                    w_ent    = 1'b1;
                    w_ent_st = (r_state == S_WSTRETCH) ? S_WACK : S_RACK;
                end
            end
            S_POLL: begin
                if (!i_item.sda_in) begin
                    n_ack_flag = 1'b1;
                    w_fin      = 1'b1;
                end else begin
                    n_awcount = r_awcount + CNT_ONE;
                    if (n_awcount >= i_wlim) begin
                        n_ack_flag = 1'b0;
                        w_fin      = 1'b1;
                    end
                end
            end
            default: begin
                // timed states: advance at the end of a quarter
                if (r_qcount >= i_qlim) begin
                    case (r_state)
                        S_START: begin
                            n_sda = 1'b0;
                            w_fin = 1'b1;
                        end
                        S_STOP: begin
                            if (r_phase == 2'd0) begin
                                w_ent = 1'b1; w_ent_st = S_STOP; w_ent_ph = 2'd1;
                            end else begin
                                n_scl = 1'b1;
                                n_sda = 1'b1;
                                w_fin = 1'b1;
                            end
                        end
                        S_WBIT: begin
                            w_ent = 1'b1;
                            if (r_phase != 2'd3) begin
                                w_ent_st = S_WBIT; w_ent_ph = r_phase + 2'd1;
                            end else begin
                                n_shift     = {r_shift[MSB_INDEX-1:0], 1'b0};
                                n_bit_count = r_bit_count + 4'd1;
                                if (n_bit_count < DATA_BITS) begin
                                    w_ent_st = S_WBIT;
                                end else begin
                                    n_bit_count = '0;
                                    w_ent_st = r_str_l ? S_WSTRETCH : S_WACK;
                                end
                            end
                        end
                        S_RBIT: begin
                            w_ent = 1'b1;
                            if (r_phase != 2'd3) begin
                                w_ent_st = S_RBIT; w_ent_ph = r_phase + 2'd1;
                            end else begin
                                n_shift     = {r_shift[MSB_INDEX-1:0], i_item.sda_in};
                                n_bit_count = r_bit_count + 4'd1;
                                if (n_bit_count < DATA_BITS) begin
                                    w_ent_st = S_RBIT;
                                end else begin
                                    n_rd_byte   = n_shift;
                                    n_bit_count = '0;
                                    w_ent_st = r_str_l ? S_RSTRETCH : S_RACK;
                                end
                            end
                        end
                        S_WACK: begin
                            w_ent = 1'b1;
                            if (r_phase == 2'd0) begin
                                w_ent_st = S_WACK; w_ent_ph = 2'd1;
                            end else begin
                                w_ent_st = S_POLL;
                            end
                        end
                        S_RACK: begin
                            if (r_phase != 2'd3) begin
                                w_ent = 1'b1; w_ent_st = S_RACK; w_ent_ph = r_phase + 2'd1;
                            end else begin
                                w_fin = 1'b1;
                            end
                        end
                        S_BRST: begin
                            if (r_phase != 2'd3) begin
                                w_ent = 1'b1; w_ent_st = S_BRST; w_ent_ph = r_phase + 2'd1;
                            end else begin
                                n_bit_count = r_bit_count + 4'd1;
                                if (n_bit_count < RESET_CLOCKS) begin
                                    w_ent = 1'b1; w_ent_st = S_BRST;
                                end else begin
                                    n_bit_count = '0;
                                    w_fin = 1'b1;
                                end
                            end
                        end
                        default: w_fin = 1'b1;
                    endcase
                end else begin
                    w_qtick = 1'b1;
                end
            end
        endcase

        // state entry: every entry path leaves the quarter counter at one
        if (w_ent) begin
            n_state  = w_ent_st;
            n_phase  = w_ent_ph;
            n_qcount = CNT_ONE;
            case (w_ent_st)
                S_START: begin
                    n_scl = 1'b1; n_sda = 1'b1;
                end
                S_STOP: begin
                    n_scl = (w_ent_ph >= 2'd1); n_sda = 1'b0;
                end
                S_WBIT: begin
                    n_scl = (w_ent_ph >= 2'd2);
                    if (w_ent_ph >= 2'd1) n_sda = n_shift[MSB_INDEX];
                end
                S_RBIT, S_BRST: begin
                    n_scl = (w_ent_ph >= 2'd2); n_sda = 1'b1;
                end
                S_WSTRETCH, S_RSTRETCH: n_scl = 1'b1;
                S_WACK: begin
                    n_scl = 1'b0; n_sda = 1'b1;
                end
                S_POLL: begin
                    n_scl = 1'b1; n_sda = 1'b1; n_awcount = '0;
                end
                S_RACK: begin
                    n_scl = (w_ent_ph >= 2'd2);
                    if (w_ent_ph >= 2'd1) n_sda = !n_ack_l;
                end
                default: ;
            endcase
        end else if (w_fin) begin
            n_state  = S_IDLE;
            n_phase  = 2'd0;
            n_qcount = '0;
            w_done   = 1'b1;
        end else if (w_qtick) begin
            n_qcount = r_qcount + CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit_count <= '0;
            r_shift     <= '0;
            r_qcount    <= '0;
            r_phase     <= 2'd0;
            r_awcount   <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_ack_flag  <= 1'b0;
            r_ack_l     <= 1'b0;
            r_str_l     <= 1'b0;
            r_rd_byte   <= '0;
        end else if (i_step) begin
            r_state     <= n_state;
            r_bit_count <= n_bit_count;
            r_shift     <= n_shift;
            r_qcount    <= n_qcount;
            r_phase     <= n_phase;
            r_awcount   <= n_awcount;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_ack_flag  <= n_ack_flag;
            r_ack_l     <= n_ack_l;
            r_str_l     <= n_str_l;
            r_rd_byte   <= n_rd_byte;
        end
    end

    always_comb begin
        o_result.scl_release = n_scl;
        o_result.sda_release = n_sda;
        o_result.busy_res    = (n_state != S_IDLE);
        o_result.done_res    = w_done;
        o_result.read_data   = n_rd_byte;
        o_result.ack_seen    = n_ack_flag;
    end

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_qcount == '0 && r_phase == 2'd0)
        else $error("idle with quarter timing not cleared");

    a_stretch_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WSTRETCH || r_state == S_RSTRETCH) |-> r_bit_count == '0)
        else $error("bit count not cleared after data bits");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WBIT || r_state == S_RBIT) |-> r_bit_count < DATA_BITS)
        else $error("data bit count out of range");

    a_ack_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_state == S_POLL && !i_item.sda_in |=> r_ack_flag && r_state == S_IDLE)
        else $error("low SDA during poll not taken as ack");

endmodule

`default_nettype wire

@@ rtl/core/i2c_master_bit_engine_core.sv @@
`default_nettype none

// I2C master bit engine.
// Input channel (i_in_valid / o_in_stall, i_in_item): one beat per SCL-timing
// tick. Each beat carries a command (tick, start, stop, write, read, bus
// reset), its operands and the sampled SCL/SDA pin levels. Commands are taken
// only while the engine is idle; otherwise they are ignored.
// Output channel (o_out_valid / i_out_stall, o_out_item): exactly one beat per
// input beat, with the open-drain drive levels, busy/done and last read/ack.
// Config channel (i_cfg_valid / o_cfg_ready, index + data): quarter_ticks (0)
// and ack_wait_ticks (1); o_cfg_ready is always high. Write only while idle.
// Path: input register, then sequencer logic, then result register. Throughput
// is one beat per cycle while the result side does not stall.
// Stall: the result register holds; the input register keeps taking beats
// until it is also full, then o_in_stall rises. No beat is dropped.
// Reset: bus released, engine idle, quarter_ticks = 125, ack_wait_ticks = 250.
module i2c_master_bit_engine_core
    import i2cm_pkg::*;
#(
    parameter int COUNTER_WIDTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_item,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    // config registers
    logic [CFG_W-1:0] r_quarter_ticks;
    logic [CFG_W-1:0] r_ack_wait_ticks;

    // input stage
    logic     r_in_valid;
    t_in_item r_in_item;

    // result stage
    logic      r_out_valid;
    t_out_item r_out_item;

    logic                     w_advance;   // result register can take a beat
    logic                     w_step;      // sequencer consumes the held beat
    logic [COUNTER_WIDTH-1:0] w_qlim;
    logic [COUNTER_WIDTH-1:0] w_wlim;
    t_out_item                w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quarter_ticks  <= QUARTER_TICKS_RST;
            r_ack_wait_ticks <= ACK_WAIT_TICKS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_QUARTER_TICKS:  r_quarter_ticks  <= i_cfg_data;
                CFG_ACK_WAIT_TICKS: r_ack_wait_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    i2cm_limit #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_qlim (
        .i_value(r_quarter_ticks),
        .o_limit(w_qlim)
    );

    i2cm_limit #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_wlim (
        .i_value(r_ack_wait_ticks),
        .o_limit(w_wlim)
    );

    assign w_advance  = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_advance;
    assign o_in_stall = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    i2cm_engine #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_item  (r_in_item),
        .i_qlim  (w_qlim),
        .i_wlim  (w_wlim),
        .o_result(w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

@@ tb/tb_i2c_master_bit_engine_core.sv @@
module tb_i2c_master_bit_engine_core;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    // cmd codes the engine does not know; it must treat them like a plain tick
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    // Upper bound on a full run, even with the longest gaps and stalls
    localparam int CYCLE_LIMIT = 2_000_000;

    // ------------------------------------------------------------------
    // DUT signals: every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_item   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_item;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    i2c_master_bit_engine_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Bit engine predictor: own copy of timing regs and sequencer state
    // ------------------------------------------------------------------
    logic [15:0] cfg_quarter;
    logic [15:0] cfg_ack_wait;

    t_state      eng_state;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic [15:0] qcount;        // ticks spent in the current quarter
    logic [1:0]  qphase;        // quarter within the bit slot
    logic [15:0] poll_cnt;      // ticks spent polling for ACK
    logic        scl_lv;
    logic        sda_lv;
    logic        ack_fl;
    logic        ack_lat;       // send_ack taken with every command, used by reads
    logic        str_lat;       // allow_stretch taken with the command
    logic [7:0]  rx_byte;
    logic        done_fl;

    // Expected result beats, oldest first
    t_out_item   expected_q[$];

    int          errors     = 0;
    int          work_items = 0;   // beats that the engine actually worked on
    int          burst_left = 0;
    int          stall_run  = 0;
    int          cycles     = 0;

    // Bus-side knobs for tick beats
    int          noise_pct   = 0;   // chance a tick beat carries a random code
    int          ack_pct     = 50;  // chance SDA reads low per ACK poll tick
    int          scl_rel_pct = 50;  // chance a stretching slave lets SCL go
    int          sda_force   = -1;  // -1 random SDA, else fixed level

    function automatic void predictor_reset();
        cfg_quarter  = QUARTER_TICKS_RST;
        cfg_ack_wait = ACK_WAIT_TICKS_RST;
        eng_state    = S_IDLE;
        bit_cnt      = '0;
        shreg        = '0;
        qcount       = '0;
        qphase       = '0;
        poll_cnt     = '0;
        scl_lv       = 1'b1;
        sda_lv       = 1'b1;
        ack_fl       = 1'b0;
        ack_lat      = 1'b0;
        str_lat      = 1'b0;
        rx_byte      = '0;
        done_fl      = 1'b0;
    endfunction

    // zero acts as one; 16-bit regs never exceed the 16-bit counters
    function automatic logic [15:0] eff_limit(input logic [15:0] r);
        return (r == 16'd0) ? 16'd1 : r;
    endfunction

    // Entering a quarter sets the pin levels for it
    function automatic void enter_state(input t_state s, input logic [1:0] ph);
        eng_state = s;
        qphase    = ph;
        qcount    = '0;
        case (s)
            S_START: begin
                scl_lv = 1'b1;
                sda_lv = 1'b1;
            end
            S_STOP: begin
                scl_lv = (ph >= 2'd1);
                sda_lv = 1'b0;
            end
            S_WBIT: begin
                scl_lv = (ph >= 2'd2);
                if (ph >= 2'd1) sda_lv = shreg[MSB_INDEX];
            end
            S_RBIT, S_BRST: begin
                scl_lv = (ph >= 2'd2);
                sda_lv = 1'b1;
            end
            S_WSTRETCH, S_RSTRETCH: scl_lv = 1'b1;
            S_WACK: begin
                scl_lv = 1'b0;
                sda_lv = 1'b1;
            end
            S_POLL: begin
                scl_lv   = 1'b1;
                sda_lv   = 1'b1;
                poll_cnt = '0;
            end
            S_RACK: begin
                scl_lv = (ph >= 2'd2);
                if (ph >= 2'd1) sda_lv = !ack_lat;
            end
            default: ;
        endcase
    endfunction

    function automatic void finish_cmd();
        eng_state = S_IDLE;
        qphase    = '0;
        qcount    = '0;
        done_fl   = 1'b1;
    endfunction

    function automatic void after_data_bits(input logic reading);
        bit_cnt = '0;
        if (str_lat) enter_state(reading ? S_RSTRETCH : S_WSTRETCH, 2'd0);
        else enter_state(reading ? S_RACK : S_WACK, 2'd0);
    endfunction

    // End of a quarter: move to the next quarter, bit or state
    function automatic void advance_quarter(input logic sda_in);
        case (eng_state)
            S_START: begin
                sda_lv = 1'b0;
                finish_cmd();
            end
            S_STOP: begin
                if (qphase == 2'd0) begin
                    enter_state(S_STOP, 2'd1);
                end else begin
                    scl_lv = 1'b1;
                    sda_lv = 1'b1;
                    finish_cmd();
                end
            end
            S_WBIT: begin
                if (qphase < 2'd3) begin
                    enter_state(S_WBIT, qphase + 2'd1);
                end else begin
                    shreg = {shreg[6:0], 1'b0};
                    bit_cnt++;
                    if (bit_cnt < DATA_BITS) enter_state(S_WBIT, 2'd0);
                    else after_data_bits(1'b0);
                end
            end
            S_RBIT: begin
                if (qphase < 2'd3) begin
                    enter_state(S_RBIT, qphase + 2'd1);
                end else begin
                    // sampled on the last SCL-high tick
                    shreg = {shreg[6:0], sda_in};
                    bit_cnt++;
                    if (bit_cnt < DATA_BITS) begin
                        enter_state(S_RBIT, 2'd0);
                    end else begin
                        rx_byte = shreg;
                        after_data_bits(1'b1);
                    end
                end
            end
            S_WACK: begin
                if (qphase == 2'd0) enter_state(S_WACK, 2'd1);
                else enter_state(S_POLL, 2'd0);
            end
            S_RACK: begin
                if (qphase < 2'd3) enter_state(S_RACK, qphase + 2'd1);
                else finish_cmd();
            end
            S_BRST: begin
                if (qphase < 2'd3) begin
                    enter_state(S_BRST, qphase + 2'd1);
                end else begin
                    bit_cnt++;
                    if (bit_cnt < RESET_CLOCKS) begin
                        enter_state(S_BRST, 2'd0);
                    end else begin
                        bit_cnt = '0;
                        finish_cmd();
                    end
                end
            end
            default: finish_cmd();
        endcase
    endfunction

    // One tick of the engine; returns the result beat it causes
    function automatic t_out_item engine_step(input t_in_item it);
        t_out_item   r;
        logic [15:0] qlim;
        logic [15:0] wlim;
        qlim    = eff_limit(cfg_quarter);
        wlim    = eff_limit(cfg_ack_wait);
        done_fl = 1'b0;
        if (eng_state == S_IDLE) begin
            // commands only count while idle; unknown codes act as a tick
            if (it.cmd >= CMD_START && it.cmd <= CMD_BRST) begin
                ack_lat = it.send_ack;
                str_lat = it.allow_stretch;
                bit_cnt = '0;
                case (it.cmd)
                    CMD_START: enter_state(S_START, 2'd0);
                    CMD_STOP:  enter_state(S_STOP, 2'd0);
                    CMD_WRITE: begin
                        shreg = it.write_data;
                        enter_state(S_WBIT, 2'd0);
                    end
                    CMD_READ: begin
                        shreg = '0;
                        enter_state(S_RBIT, 2'd0);
                    end
                    default: enter_state(S_BRST, 2'd0);
                endcase
                // accepting tick is the first tick of quarter 0
                qcount = 16'd1;
            end
        end else if (eng_state == S_WSTRETCH || eng_state == S_RSTRETCH) begin
            if (it.scl_in) begin
                enter_state((eng_state == S_WSTRETCH) ? S_WACK : S_RACK, 2'd0);
                qcount = 16'd1;
            end
        end else if (eng_state == S_POLL) begin
            if (!it.sda_in) begin
                ack_fl = 1'b1;
                finish_cmd();
            end else begin
                poll_cnt++;
                if (poll_cnt >= wlim) begin
                    ack_fl = 1'b0;
                    finish_cmd();
                end
            end
        end else begin
            if (qcount >= qlim) advance_quarter(it.sda_in);
            if (eng_state != S_IDLE && qcount < qlim) qcount++;
        end
        r.scl_release = scl_lv;
        r.sda_release = sda_lv;
        r.busy_res    = (eng_state != S_IDLE);
        r.done_res    = done_fl;
        r.read_data   = rx_byte;
        r.ack_seen    = ack_fl;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Tick beat as a bus would see it: stretching slave, ACK from slave, noise
    function automatic t_in_item tick_item();
        t_in_item it;
        it.cmd           = ($urandom_range(0, 99) < noise_pct) ? 3'($urandom_range(0, 7))
                                                                : CMD_TICK;
        it.write_data    = 8'($urandom);
        it.send_ack      = 1'($urandom);
        it.allow_stretch = 1'($urandom);
        if (eng_state == S_WSTRETCH || eng_state == S_RSTRETCH)
            it.scl_in = ($urandom_range(0, 99) < scl_rel_pct);
        else
            it.scl_in = 1'($urandom);
        if (eng_state == S_POLL)
            it.sda_in = !($urandom_range(0, 99) < ack_pct);
        else if (sda_force >= 0)
            it.sda_in = sda_force[0];
        else
            it.sda_in = 1'($urandom);
        return it;
    endfunction

    // Sends one beat; the sender runs in bursts with random gaps.
    // Called at a rising edge; returns at the edge that took the beat.
    task automatic send_beat(input t_in_item it);
        t_out_item r;
        int        gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        r = engine_step(it);
        expected_q.push_back(r);
        if (r.busy_res || r.done_res) work_items++;
    endtask

    // Issue one command, then tick until the engine goes idle
    task automatic run_cmd(input logic [2:0] c, input logic [7:0] d,
                           input logic ack, input logic str);
        t_in_item it;
        it               = tick_item();
        it.cmd           = c;
        it.write_data    = d;
        it.send_ack      = ack;
        it.allow_stretch = str;
        send_beat(it);
        while (eng_state != S_IDLE) send_beat(tick_item());
    endtask

    // Sender holds off until every expected beat has come back
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    // Timing regs are only written with the engine idle and nothing in flight
    task automatic set_timing(input logic [15:0] qt, input logic [15:0] aw);
        while (eng_state != S_IDLE) send_beat(tick_item());
        wait_results_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_QUARTER_TICKS;
        i_cfg_data  <= qt;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_ACK_WAIT_TICKS;
        i_cfg_data  <= aw;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_quarter  = qt;
        cfg_ack_wait = aw;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset quarter length (125) without touching the regs
    task automatic test_reset_defaults();
        run_cmd(CMD_START, 8'h00, 1'b0, 1'b0);
    endtask

    task automatic test_directed_commands();
        set_timing(16'd1, 16'd3);
        noise_pct = 0;
        run_cmd(CMD_START, 8'h00, 1'b0, 1'b0);
        // write all ones, slave ACKs at once
        ack_pct = 100;
        run_cmd(CMD_WRITE, 8'hFF, 1'b0, 1'b0);
        // write all zeros, slave never ACKs -> poll timeout, no ack
        ack_pct = 0;
        run_cmd(CMD_WRITE, 8'h00, 1'b1, 1'b0);
        // clock stretch after the data bits; slave holds SCL low a while
        ack_pct     = 50;
        scl_rel_pct = 10;
        run_cmd(CMD_WRITE, 8'hA5, 1'b0, 1'b1);
        scl_rel_pct = 30;
        // reads of all ones with ACK and all zeros with NACK after a stretch
        sda_force = 1;
        run_cmd(CMD_READ, 8'hFF, 1'b1, 1'b0);
        sda_force = 0;
        run_cmd(CMD_READ, 8'h00, 1'b0, 1'b1);
        sda_force = -1;
        run_cmd(CMD_BRST, 8'h5A, 1'b1, 1'b1);
        run_cmd(CMD_STOP, 8'h00, 1'b0, 1'b0);
        // unknown codes and a bare tick while idle do nothing
        run_cmd(CMD_RSVD6, 8'hFF, 1'b1, 1'b1);
        run_cmd(CMD_RSVD7, 8'h00, 1'b0, 1'b0);
        run_cmd(CMD_TICK, 8'hC3, 1'b1, 1'b1);
        // every busy tick carries a random code, the completing tick included
        noise_pct = 100;
        run_cmd(CMD_WRITE, 8'h5A, 1'b1, 1'b1);
        noise_pct = 0;
        // zero timing regs behave like one
        set_timing(16'd0, 16'd0);
        run_cmd(CMD_START, 8'h00, 1'b0, 1'b0);
        run_cmd(CMD_WRITE, 8'h3C, 1'b0, 1'b1);
        run_cmd(CMD_STOP, 8'h00, 1'b0, 1'b0);
    endtask

    // Largest ACK window: slave answers late
    task automatic test_timing_extremes();
        noise_pct = 10;
        set_timing(16'd1, 16'hFFFF);
        ack_pct = 5;
        run_cmd(CMD_WRITE, 8'($urandom), 1'b0, 1'b1);
        noise_pct = 0;
    endtask

    // Mostly start / byte / stop transactions, some stray commands
    task automatic test_random_traffic();
        logic [15:0] qt_set [3] = '{16'd1, 16'd0, 16'd2};
        logic [15:0] aw_set [3] = '{16'd24, 16'd0, 16'd4};
        for (int p = 0; p < 3; p++) begin
            set_timing(qt_set[p], aw_set[p]);
            noise_pct   = $urandom_range(0, 30);
            ack_pct     = $urandom_range(20, 95);
            scl_rel_pct = $urandom_range(25, 100);
            sda_force   = -1;
            work_items  = 0;
            while (work_items < 40) begin
                if ($urandom_range(0, 4) == 0) begin
                    // idle noise then any code at all
                    repeat ($urandom_range(0, 3)) send_beat(tick_item());
                    run_cmd(3'($urandom_range(0, 7)), 8'($urandom),
                            1'($urandom), 1'($urandom));
                end else begin
                    run_cmd(CMD_START, 8'($urandom), 1'($urandom), 1'($urandom));
                    run_cmd($urandom_range(0, 1) ? CMD_WRITE : CMD_READ,
                            8'($urandom), 1'($urandom), 1'($urandom));
                    run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), 1'($urandom));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern and beat checker
    // ------------------------------------------------------------------

    // Receiver mixes flow runs and stall runs of random length
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                stall_run = $urandom_range(1, 8);
            end else begin
                i_out_stall <= 1'b0;
                stall_run = $urandom_range(1, 30);
            end
        end else begin
            stall_run--;
        end
    end

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_out_item exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                $display("%0t: result beat with nothing expected: %h", $time, o_out_item);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                check_field("scl_release", 8'(exp_r.scl_release),
                            8'(o_out_item.scl_release));
                check_field("sda_release", 8'(exp_r.sda_release),
                            8'(o_out_item.sda_release));
                check_field("busy_res", 8'(exp_r.busy_res), 8'(o_out_item.busy_res));
                check_field("done_res", 8'(exp_r.done_res), 8'(o_out_item.done_res));
                check_field("read_data", exp_r.read_data, o_out_item.read_data);
                check_field("ack_seen", 8'(exp_r.ack_seen), 8'(o_out_item.ack_seen));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        predictor_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_commands();
        test_timing_extremes();
        test_random_traffic();

        // let the last beats come out, then keep watching for stray ones
        wait_results_drained();
        repeat (4) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
